// File: rtl/core/cbpw_pkg.sv
// Shared types, constants and the sequencer microcode table of the Bezier path walker.
`default_nettype none

package cbpw_pkg;

  localparam int COORD_BITS  = 16;
  localparam int MAX_POINTS  = 64;
  localparam int STEPS_DEF   = 40;
  localparam int ADDR_W      = $clog2(MAX_POINTS);
  localparam int CNT_W       = 7;
  localparam int POINT_W     = 3 * COORD_BITS;
  localparam int T_W         = 17;
  localparam int ACC_W       = 22;
  localparam int PC_W        = 4;

  localparam logic       ACT_LOAD = 1'b0;
  localparam logic       ACT_STEP = 1'b1;

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;

  localparam logic [1:0] SEL_P0 = 2'd0;
  localparam logic [1:0] SEL_P1 = 2'd1;
  localparam logic [1:0] SEL_P2 = 2'd2;
  localparam logic [1:0] SEL_P3 = 2'd3;

  localparam logic [PC_W-1:0] PC_FIRST = 4'd0;
  localparam logic [PC_W-1:0] PC_LOOP  = 4'd5;
  localparam logic [PC_W-1:0] PC_DONE  = 4'd9;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD_A,
    OP_MAC_B,
    OP_MAC_C,
    OP_MAC_D
  } op_e;

  typedef struct packed {
    logic       rd_en;
    logic [1:0] rd_off;
    logic       lat_en;
    logic [1:0] lat_sel;
    op_e        op;
    logic       loop;
    logic       done;
  } ucode_t;

  typedef struct packed {
    ucode_t     uw;
    logic [1:0] axis;
  } dp_ctrl_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{rd_en: 1'b0, rd_off: SEL_P0, lat_en: 1'b0, lat_sel: SEL_P0, op: OP_NONE,
          loop: 1'b0, done: 1'b0};
    case (pc)
      4'd0: begin
        w.rd_en = 1'b1; w.rd_off = SEL_P0;
      end
      4'd1: begin
        w.rd_en = 1'b1; w.rd_off = SEL_P1; w.lat_en = 1'b1; w.lat_sel = SEL_P0;
      end
      4'd2: begin
        w.rd_en = 1'b1; w.rd_off = SEL_P2; w.lat_en = 1'b1; w.lat_sel = SEL_P1;
      end
      4'd3: begin
        w.rd_en = 1'b1; w.rd_off = SEL_P3; w.lat_en = 1'b1; w.lat_sel = SEL_P2;
      end
      4'd4: begin
        w.lat_en = 1'b1; w.lat_sel = SEL_P3;
      end
      4'd5: w.op = OP_LOAD_A;
      4'd6: w.op = OP_MAC_B;
      4'd7: w.op = OP_MAC_C;
      4'd8: begin
        w.op = OP_MAC_D; w.loop = 1'b1;
      end
      4'd9: w.done = 1'b1;
      default: w.op = OP_NONE;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/cbpw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module cbpw_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/cbpw_datapath.sv
// Point registers, coefficient logic and the shared Horner multiplier of the path walker.
`default_nettype none

module cbpw_datapath
  import cbpw_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire dp_ctrl_t                     ctrl_i,
  input  wire logic [POINT_W-1:0]           rdata_i,
  input  wire logic [T_W-1:0]               t_i,
  output logic signed [COORD_BITS-1:0]      res_x_o,
  output logic signed [COORD_BITS-1:0]      res_y_o,
  output logic signed [COORD_BITS-1:0]      res_z_o
);

  logic [POINT_W-1:0] p0_q, p1_q, p2_q, p3_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [COORD_BITS-1:0] res_x_q, res_y_q, res_z_q;
  logic signed [COORD_BITS-1:0] c0, c1, c2, c3, sat_val;
  logic signed [ACC_W-1:0] e0, e1, e2, e3, coef_a, coef_b, coef_c, coef_d, d12, d01, s012;
  logic signed [ACC_W+T_W:0] prod;
  logic signed [ACC_W-1:0] prod_sh;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (COORD_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  always_comb begin
    unique case (ctrl_i.axis)
      AXIS_Y: begin
        c0 = p0_q[2*COORD_BITS-1:COORD_BITS]; c1 = p1_q[2*COORD_BITS-1:COORD_BITS];
        c2 = p2_q[2*COORD_BITS-1:COORD_BITS]; c3 = p3_q[2*COORD_BITS-1:COORD_BITS];
      end
      AXIS_Z: begin
        c0 = p0_q[3*COORD_BITS-1:2*COORD_BITS]; c1 = p1_q[3*COORD_BITS-1:2*COORD_BITS];
        c2 = p2_q[3*COORD_BITS-1:2*COORD_BITS]; c3 = p3_q[3*COORD_BITS-1:2*COORD_BITS];
      end
      default: begin
        c0 = p0_q[COORD_BITS-1:0]; c1 = p1_q[COORD_BITS-1:0];
        c2 = p2_q[COORD_BITS-1:0]; c3 = p3_q[COORD_BITS-1:0];
      end
    endcase
  end

  assign e0 = ACC_W'(c0);
  assign e1 = ACC_W'(c1);
  assign e2 = ACC_W'(c2);
  assign e3 = ACC_W'(c3);

  // Power-form coefficients built from shifts and adds.
  assign d12    = e1 - e2;
  assign d01    = e1 - e0;
  assign s012   = e0 - (e1 <<< 1) + e2;
  assign coef_a = e3 - e0 + (d12 <<< 1) + d12;
  assign coef_b = (s012 <<< 1) + s012;
  assign coef_c = (d01 <<< 1) + d01;
  assign coef_d = e0;

  assign prod    = acc_q * $signed({1'b0, t_i});
  assign prod_sh = prod[ACC_W+15:16];

  always_comb begin
    case (ctrl_i.uw.op)
      OP_LOAD_A: acc_d = coef_a;
      OP_MAC_B:  acc_d = prod_sh + coef_b;
      OP_MAC_C:  acc_d = prod_sh + coef_c;
      OP_MAC_D:  acc_d = prod_sh + coef_d;
      default:   acc_d = acc_q;
    endcase
  end

  always_comb begin
    if (acc_d > SAT_HI) begin
      sat_val = COORD_BITS'(SAT_HI);
    end else if (acc_d < SAT_LO) begin
      sat_val = COORD_BITS'(SAT_LO);
    end else begin
      sat_val = acc_d[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (ctrl_i.uw.lat_en) begin
      unique case (ctrl_i.uw.lat_sel)
        SEL_P0:  p0_q <= rdata_i;
        SEL_P1:  p1_q <= rdata_i;
        SEL_P2:  p2_q <= rdata_i;
        default: p3_q <= rdata_i;
      endcase
    end
    if (ctrl_i.uw.op == OP_MAC_D) begin
      unique case (ctrl_i.axis)
        AXIS_Y:  res_y_q <= sat_val;
        AXIS_Z:  res_z_q <= sat_val;
        default: res_x_q <= sat_val;
      endcase
    end
  end

  assign res_x_o = res_x_q;
  assign res_y_o = res_y_q;
  assign res_z_o = res_z_q;

endmodule

`default_nettype wire

// File: rtl/core/cubic_bezier_path_walker.sv
// Top level of the cubic Bezier path walker: request handling, sequencer and path state.
//
// Requests arrive on the input channel (in_valid_i, in_stall_o). A load request
// (action 0) writes one control point into the point RAM in the cycle it is taken
// and gives no result. A step request (action 1) advances the sample counter and
// runs the microcode program: four RAM reads, then a coefficient load and three
// Horner steps per axis on one shared multiplier. Its result appears on the output
// channel (out_valid_o, out_stall_i) once the program ends. No request is taken
// while a step runs (in_stall_o is high); loads are taken at one per cycle while
// no step runs. The program reads and latches the points through the single RAM
// read port, runs the coefficient load and Horner steps for each axis on the single
// multiplier and then hands the result to the output register.
// The finished result sits in an output register; while the receiver stalls,
// further requests are still taken, and a second step only waits at its final
// microcode step until the register is free. The point_count register must be
// written through cfg_we_i and cfg_wdata_i while idle; the block does not enforce it.
// Reset clears the segment start, the sample counter and the result valid, and
// sets point_count to 4. The point RAM is not cleared; points must be loaded
// before a step reads them.
`default_nettype none

module cubic_bezier_path_walker
  import cbpw_pkg::*;
#(
  parameter int STEPS = STEPS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         action_i,
  input  wire logic [ADDR_W-1:0]            point_index_i,
  input  wire logic signed [COORD_BITS-1:0] point_x_i,
  input  wire logic signed [COORD_BITS-1:0] point_y_i,
  input  wire logic signed [COORD_BITS-1:0] point_z_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0]      pos_x_o,
  output logic signed [COORD_BITS-1:0]      pos_y_o,
  output logic signed [COORD_BITS-1:0]      pos_z_o,
  output logic [ADDR_W-1:0]                 segment_index_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [CNT_W-1:0]             cfg_wdata_i
);

  localparam int KW   = $clog2(STEPS + 1);
  localparam int RW   = $clog2(STEPS);
  localparam int TQ   = 65536 / STEPS;
  localparam int TR   = 65536 % STEPS;

  logic                  running_q;
  logic [PC_W-1:0]       pc_q;
  logic [1:0]            axis_q;
  logic [CNT_W-1:0]      point_count_q;
  logic [ADDR_W-1:0]     seg_q, seg_use_q;
  logic [KW-1:0]         step_q;
  logic [RW-1:0]         rem_q;
  logic [T_W-1:0]        t_q, t_use_q;
  logic                  out_valid_q;
  logic signed [COORD_BITS-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic [ADDR_W-1:0]     seg_out_q;

  logic                  in_acc, step_acc, load_acc, out_free, carry;
  logic [CNT_W-1:0]      n_use;
  logic [ADDR_W-1:0]     s_eff;
  logic [KW-1:0]         k;
  logic [RW:0]           rem_sum;
  logic [RW-1:0]         rem_nxt;
  logic [T_W-1:0]        t_nxt;
  ucode_t                uw;
  dp_ctrl_t              dp_ctrl;
  logic [POINT_W-1:0]    rdata;
  logic signed [COORD_BITS-1:0] res_x, res_y, res_z;

  assign in_stall_o = running_q;
  assign in_acc     = in_valid_i && !running_q;
  assign step_acc   = in_acc && (action_i == ACT_STEP);
  assign load_acc   = in_acc && (action_i == ACT_LOAD);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    if (point_count_q < CNT_W'(4)) begin
      n_use = CNT_W'(4);
    end else if (point_count_q > CNT_W'(MAX_POINTS)) begin
      n_use = CNT_W'(MAX_POINTS);
    end else begin
      n_use = point_count_q;
    end
  end

  assign s_eff   = (({1'b0, seg_q} + 7'd3) >= n_use) ? '0 : seg_q;
  assign k       = step_q + KW'(1);
  assign rem_sum = {1'b0, rem_q} + (RW+1)'(TR);
  assign carry   = rem_sum >= (RW+1)'(STEPS);
  assign rem_nxt = carry ? RW'(rem_sum - (RW+1)'(STEPS)) : rem_sum[RW-1:0];
  assign t_nxt   = t_q + T_W'(TQ) + T_W'(carry);

  assign uw = running_q ? ucode_rom(pc_q) : ucode_rom(PC_DONE) & '0;
  assign dp_ctrl = '{uw: uw, axis: axis_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q     <= 1'b0;
      pc_q          <= PC_FIRST;
      axis_q        <= AXIS_X;
      point_count_q <= CNT_W'(4);
      seg_q         <= '0;
      step_q        <= '0;
      rem_q         <= '0;
      t_q           <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        point_count_q <= cfg_wdata_i;
      end
      if (step_acc) begin
        running_q <= 1'b1;
        pc_q      <= PC_FIRST;
        axis_q    <= AXIS_X;
        if (k == KW'(STEPS)) begin
          step_q <= '0;
          rem_q  <= '0;
          t_q    <= '0;
          seg_q  <= (({1'b0, s_eff} + 7'd6) >= n_use) ? '0 : s_eff + ADDR_W'(3);
        end else begin
          step_q <= k;
          rem_q  <= rem_nxt;
          t_q    <= t_nxt;
          seg_q  <= s_eff;
        end
      end else if (running_q) begin
        if (uw.done) begin
          if (out_free) begin
            running_q <= 1'b0;
          end
        end else if (uw.loop && (axis_q != AXIS_Z)) begin
          pc_q   <= PC_LOOP;
          axis_q <= axis_q + 2'd1;
        end else begin
          pc_q <= pc_q + PC_W'(1);
        end
      end
      if (running_q && uw.done && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_acc) begin
      seg_use_q <= s_eff;
      t_use_q   <= t_nxt;
    end
    if (running_q && uw.done && out_free) begin
      pos_x_q   <= res_x;
      pos_y_q   <= res_y;
      pos_z_q   <= res_z;
      seg_out_q <= seg_use_q;
    end
  end

  cbpw_ram #(
    .WIDTH (POINT_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (load_acc),
    .waddr_i (point_index_i),
    .wdata_i ({point_z_i, point_y_i, point_x_i}),
    .re_i    (uw.rd_en),
    .raddr_i (seg_use_q + ADDR_W'(uw.rd_off)),
    .rdata_o (rdata)
  );

  cbpw_datapath u_dp (
    .clk_i   (clk_i),
    .ctrl_i  (dp_ctrl),
    .rdata_i (rdata),
    .t_i     (t_use_q),
    .res_x_o (res_x),
    .res_y_o (res_y),
    .res_z_o (res_z)
  );

  assign out_valid_o     = out_valid_q;
  assign pos_x_o         = pos_x_q;
  assign pos_y_o         = pos_y_q;
  assign pos_z_o         = pos_z_q;
  assign segment_index_o = seg_out_q;

  a_step_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_acc |=> running_q && (pc_q == PC_FIRST) && (axis_q == AXIS_X))
    else $error("step request did not start the program");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (pc_q <= PC_DONE))
    else $error("microcode step counter ran past the program");

  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, seg_q} + 7'd3) < 7'(MAX_POINTS))
    else $error("segment start reads past the point table");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q < KW'(STEPS))
    else $error("sample counter out of range");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(running_q && (pc_q == PC_DONE)))
    else $error("result valid rose outside the final step");

endmodule

`default_nettype wire
